// ===== rtl/cdfis_pkg.sv =====
// Shared types and constants for the CDF table inverse sampler.
`default_nettype none

package cdfis_pkg;

    // Defaults for the top-level parameters
    localparam int TABLE_DEPTH_DEF  = 1024;
    localparam int WEIGHT_BITS_DEF  = 16;
    localparam int UNIFORM_BITS_DEF = 16;

    // Fixed field widths
    localparam int VALUE_W  = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Operation codes carried on the input beat
    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR  = 2'd0,
        FN_APPEND = 2'd1,
        FN_SAMPLE = 2'd2,
        FN_UNUSED = 2'd3
    } t_func;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Classified command handed from front to back
    typedef enum logic [1:0] {
        K_CLEAR,
        K_APPEND,
        K_SAMPLE,
        K_NOP
    } t_kind;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BS_IDLE,
        BS_SCALE,
        BS_PROBE,
        BS_COMPARE,
        BS_DONE
    } t_bstate;

endpackage

`default_nettype wire

// ===== rtl/cdf_table_inverse_sampler.sv =====
// Top level of the CDF table inverse-transform sampler.
//
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_stall    | i_func, i_point_value, i_weight, i_uniform
//  result  | out       | o_out_valid / i_out_stall  | o_sample_value, o_sample_index, o_status
//
// Clear, append and skipped items are finished straight from idle, with no search.
// A sample does one read of the cumulative-weight memory and one compare per
// search step, plus scaling, value fetch and output load.
// A two-beat command queue lets the input side run ahead of the search.
// Reset (synchronous, active low) empties the table and the queue; no clearing pass.
// A stalled result holds in the output register; the back end waits on it.
`default_nettype none

module cdf_table_inverse_sampler #(
    parameter int TABLE_DEPTH  = cdfis_pkg::TABLE_DEPTH_DEF,
    parameter int WEIGHT_BITS  = cdfis_pkg::WEIGHT_BITS_DEF,
    parameter int UNIFORM_BITS = cdfis_pkg::UNIFORM_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [cdfis_pkg::FUNC_W-1:0]    i_func,
    input  logic [cdfis_pkg::VALUE_W-1:0]   i_point_value,
    input  logic [WEIGHT_BITS-1:0]          i_weight,
    input  logic [UNIFORM_BITS-1:0]         i_uniform,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [cdfis_pkg::VALUE_W-1:0]   o_sample_value,
    output logic [$clog2(TABLE_DEPTH)-1:0]  o_sample_index,
    output logic [cdfis_pkg::STATUS_W-1:0]  o_status
);
    import cdfis_pkg::*;

    logic                    q_valid;
    logic                    q_pop;
    t_kind                   q_kind;
    logic [VALUE_W-1:0]      q_value;
    logic [WEIGHT_BITS-1:0]  q_weight;
    logic [UNIFORM_BITS-1:0] q_uniform;

    // Accept and classify
    cdfis_front #(
        .WEIGHT_BITS  (WEIGHT_BITS),
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_point_value (i_point_value),
        .i_weight      (i_weight),
        .i_uniform     (i_uniform),
        .o_q_valid     (q_valid),
        .i_q_pop       (q_pop),
        .o_q_kind      (q_kind),
        .o_q_value     (q_value),
        .o_q_weight    (q_weight),
        .o_q_uniform   (q_uniform)
    );

    // Execute against the table
    cdfis_back #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .WEIGHT_BITS  (WEIGHT_BITS),
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .o_q_pop        (q_pop),
        .i_q_kind       (q_kind),
        .i_q_value      (q_value),
        .i_q_weight     (q_weight),
        .i_q_uniform    (q_uniform),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_value (o_sample_value),
        .o_sample_index (o_sample_index),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire

// ===== rtl/cdfis_front.sv =====
// Front end: accepts input beats, classifies them and queues them for the back end.
`default_nettype none

module cdfis_front #(
    parameter int WEIGHT_BITS  = cdfis_pkg::WEIGHT_BITS_DEF,
    parameter int UNIFORM_BITS = cdfis_pkg::UNIFORM_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [cdfis_pkg::FUNC_W-1:0]  i_func,
    input  logic [cdfis_pkg::VALUE_W-1:0] i_point_value,
    input  logic [WEIGHT_BITS-1:0]        i_weight,
    input  logic [UNIFORM_BITS-1:0]       i_uniform,
    // queue head towards the back end
    output logic                          o_q_valid,
    input  logic                          i_q_pop,
    output cdfis_pkg::t_kind              o_q_kind,
    output logic [cdfis_pkg::VALUE_W-1:0] o_q_value,
    output logic [WEIGHT_BITS-1:0]        o_q_weight,
    output logic [UNIFORM_BITS-1:0]       o_q_uniform
);
    import cdfis_pkg::*;

    t_kind                   kind;
    logic                    push;
    logic                    pop;
    logic [QPTR_W-1:0]       r_wr_ptr;
    logic [QPTR_W-1:0]       r_rd_ptr;
    logic [QCNT_W-1:0]       r_count;
    logic [QCNT_W-1:0]       n_count;
    t_kind                   r_q_kind    [QUEUE_DEPTH];
    logic [VALUE_W-1:0]      r_q_value   [QUEUE_DEPTH];
    logic [WEIGHT_BITS-1:0]  r_q_weight  [QUEUE_DEPTH];
    logic [UNIFORM_BITS-1:0] r_q_uniform [QUEUE_DEPTH];

    // Classify the beat; a zero-weight append does nothing
    always_comb begin
        unique case (t_func'(i_func))
            FN_CLEAR:  kind = K_CLEAR;
            FN_APPEND: kind = (i_weight == '0) ? K_NOP : K_APPEND;
            FN_SAMPLE: kind = K_SAMPLE;
            default:   kind = K_NOP;
        endcase
    end

    // Queue handshake
    assign o_in_stall = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign pop        = i_q_pop && o_q_valid;

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_kind[r_wr_ptr]    <= kind;
            r_q_value[r_wr_ptr]   <= i_point_value;
            r_q_weight[r_wr_ptr]  <= i_weight;
            r_q_uniform[r_wr_ptr] <= i_uniform;
        end
    end

    assign o_q_kind    = r_q_kind[r_rd_ptr];
    assign o_q_value   = r_q_value[r_rd_ptr];
    assign o_q_weight  = r_q_weight[r_rd_ptr];
    assign o_q_uniform = r_q_uniform[r_rd_ptr];

endmodule

`default_nettype wire

// ===== rtl/cdfis_back.sv =====
// Back end: table storage, append/clear execution and binary-search sampling.
`default_nettype none

module cdfis_back #(
    parameter int TABLE_DEPTH  = cdfis_pkg::TABLE_DEPTH_DEF,
    parameter int WEIGHT_BITS  = cdfis_pkg::WEIGHT_BITS_DEF,
    parameter int UNIFORM_BITS = cdfis_pkg::UNIFORM_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // queue head from the front end
    input  logic                            i_q_valid,
    output logic                            o_q_pop,
    input  cdfis_pkg::t_kind                i_q_kind,
    input  logic [cdfis_pkg::VALUE_W-1:0]   i_q_value,
    input  logic [WEIGHT_BITS-1:0]          i_q_weight,
    input  logic [UNIFORM_BITS-1:0]         i_q_uniform,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [cdfis_pkg::VALUE_W-1:0]   o_sample_value,
    output logic [$clog2(TABLE_DEPTH)-1:0]  o_sample_index,
    output logic [cdfis_pkg::STATUS_W-1:0]  o_status
);
    import cdfis_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CUM_W  = WEIGHT_BITS + IDX_W;
    localparam int PROD_W = UNIFORM_BITS + CUM_W;

    t_bstate                 r_state;
    t_bstate                 n_state;

    logic [CNT_W-1:0]        r_count;
    logic [CUM_W-1:0]        r_total;
    logic [CUM_W-1:0]        new_total;
    logic [CNT_W-1:0]        cnt_m1;
    logic                    full;

    logic [UNIFORM_BITS-1:0] r_uniform;
    logic [PROD_W-1:0]       prod;
    logic [CUM_W-1:0]        r_scaled;
    logic [IDX_W-1:0]        r_lo;
    logic [IDX_W-1:0]        r_hi;
    logic [IDX_W-1:0]        mid;
    logic [CUM_W-1:0]        r_cum_rd;
    logic [VALUE_W-1:0]      r_val_rd;

    logic [VALUE_W-1:0]      mem_val [TABLE_DEPTH];
    logic [CUM_W-1:0]        mem_cum [TABLE_DEPTH];

    logic                    out_free;
    logic                    imm_done;
    logic                    start_sample;
    logic                    done_load;
    logic                    mem_wr;
    t_status                 imm_status;

    logic                    r_out_valid;
    logic [VALUE_W-1:0]      r_out_value;
    logic [IDX_W-1:0]        r_out_index;
    t_status                 r_out_status;

    assign full      = (r_count == CNT_W'(TABLE_DEPTH));
    assign new_total = r_total + CUM_W'(i_q_weight);
    assign cnt_m1    = r_count - CNT_W'(1);
    assign mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign prod      = PROD_W'(r_uniform) * PROD_W'(r_total);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Control outputs of the sequencer
    always_comb begin
        o_q_pop      = 1'b0;
        imm_done     = 1'b0;
        start_sample = 1'b0;
        done_load    = 1'b0;
        mem_wr       = 1'b0;
        imm_status   = ST_OK;
        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    if (i_q_kind == K_SAMPLE && r_count != '0) begin
                        start_sample = 1'b1;
                    end else begin
                        imm_done = 1'b1;
                    end
                    if (i_q_kind == K_SAMPLE && r_count == '0) begin
                        imm_status = ST_EMPTY;
                    end else if (i_q_kind == K_APPEND && full) begin
                        imm_status = ST_FULL;
                    end
                    mem_wr = (i_q_kind == K_APPEND) && !full;
                end
            end
            BS_DONE: begin
                done_load = out_free;
            end
            default: begin
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE:    if (start_sample) n_state = BS_SCALE;
            BS_SCALE:   n_state = BS_PROBE;
            BS_PROBE:   n_state = (r_lo < r_hi) ? BS_COMPARE : BS_DONE;
            BS_COMPARE: n_state = BS_PROBE;
            BS_DONE:    if (out_free) n_state = BS_IDLE;
            default:    n_state = BS_IDLE;
        endcase
    end

    // State and table bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_count <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            if (imm_done && i_q_kind == K_CLEAR) begin
                r_count <= '0;
                r_total <= '0;
            end else if (mem_wr) begin
                r_count <= r_count + CNT_W'(1);
                r_total <= new_total;
            end
        end
    end

    // Search datapath
    always_ff @(posedge i_clk) begin
        if (start_sample) begin
            r_uniform <= i_q_uniform;
            r_lo      <= '0;
            r_hi      <= cnt_m1[IDX_W-1:0];
        end
        if (r_state == BS_SCALE) begin
            r_scaled <= prod[PROD_W-1:UNIFORM_BITS];
        end
        // target is scaled + 1, so reaching it means exceeding scaled
        if (r_state == BS_COMPARE) begin
            if (r_cum_rd > r_scaled) begin
                r_hi <= mid;
            end else begin
                r_lo <= mid + IDX_W'(1);
            end
        end
    end

    // Table memories
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            mem_val[r_count[IDX_W-1:0]] <= i_q_value;
            mem_cum[r_count[IDX_W-1:0]] <= new_total;
        end
        r_cum_rd <= mem_cum[mid];
        r_val_rd <= mem_val[r_lo];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (imm_done || done_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (imm_done) begin
            r_out_value  <= '0;
            r_out_index  <= '0;
            r_out_status <= imm_status;
        end else if (done_load) begin
            r_out_value  <= r_val_rd;
            r_out_index  <= r_lo;
            r_out_status <= ST_OK;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_out_value;
    assign o_sample_index = r_out_index;
    assign o_status       = r_out_status;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the CDF table inverse sampler: random beats against a table predictor.
`timescale 1ns / 1ps

module testbench;
    import cdfis_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CUM_W       = 26;
    localparam int ITEM_GOAL   = 1500;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        t_func       func;
        logic [31:0] point_value;
        logic [15:0] weight;
        logic [15:0] uniform;
    } t_item;

    typedef struct {
        logic [31:0]      value;
        logic [IDX_W-1:0] index;
        t_status          status;
    } t_draw;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [FUNC_W-1:0]   i_func = '0;
    logic [VALUE_W-1:0]  i_point_value = '0;
    logic [15:0]         i_weight = '0;
    logic [15:0]         i_uniform = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [VALUE_W-1:0]  o_sample_value;
    logic [IDX_W-1:0]    o_sample_index;
    logic [STATUS_W-1:0] o_status;

    cdf_table_inverse_sampler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_point_value  (i_point_value),
        .i_weight       (i_weight),
        .i_uniform      (i_uniform),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_value (o_sample_value),
        .o_sample_index (o_sample_index),
        .o_status       (o_status)
    );

    always #5 i_clk = ~i_clk;

    // Predicted table state
    logic [31:0]      tbl_value [DEPTH];
    logic [CUM_W-1:0] tbl_cum [DEPTH];
    int unsigned      tbl_count = 0;
    logic [CUM_W-1:0] tbl_total = '0;

    t_item items_to_send[$];
    t_draw pending_draws[$];
    int    beats_in = 0;
    int    beats_out = 0;
    int    errors = 0;
    int    items_made = 0;
    bit    in_taken = 1'b0;

    // Sender burst / gap counters
    int burst_left = 0;
    int gap_left = 0;

    // Receiver stall pattern and the one long hold-off
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // Apply one beat to the predicted table and work out the result it gives
    function automatic t_draw apply_to_table(t_item it);
        t_draw             r;
        longint unsigned   target;
        int unsigned       lo;
        int unsigned       hi;
        int unsigned       mid;
        r.value  = '0;
        r.index  = '0;
        r.status = ST_OK;
        case (it.func)
            FN_CLEAR: begin
                tbl_count = 0;
                tbl_total = '0;
            end
            FN_APPEND: begin
                if (it.weight != 0) begin
                    if (tbl_count >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        tbl_total = tbl_total + it.weight;
                        tbl_value[tbl_count] = it.point_value;
                        tbl_cum[tbl_count] = tbl_total;
                        tbl_count++;
                    end
                end
            end
            FN_SAMPLE: begin
                if (tbl_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // scaled fraction of the total, then first bin reaching it
                    target = ((longint'(it.uniform) * longint'(tbl_total)) >> 16) + 1;
                    lo = 0;
                    hi = tbl_count - 1;
                    while (lo < hi) begin
                        mid = (lo + hi) / 2;
                        if (tbl_cum[mid] >= target) hi = mid;
                        else lo = mid + 1;
                    end
                    r.value = tbl_value[lo];
                    r.index = lo[IDX_W-1:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("beat %0d: %s got %0h want %0h", beats_out, what, got, want);
        errors++;
    endtask

    task automatic add_item(input t_func f, input logic [31:0] v, input logic [15:0] w,
                            input logic [15:0] u);
        t_item it;
        it.func        = f;
        it.point_value = v;
        it.weight      = w;
        it.uniform     = u;
        items_to_send.push_back(it);
        if (!(f == FN_UNUSED || (f == FN_APPEND && w == 0))) items_made++;
    endtask

    function automatic logic [15:0] pick_uniform();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_weight(int style);
        case (style)
            0: return 16'($urandom_range(1, 3));
            1: return 16'($urandom_range(1, 65535));
            2: return 16'hFFFF;
            default: return ($urandom_range(0, 4) == 0) ? 16'h0 : 16'($urandom);
        endcase
    endfunction

    // One well-formed run: usually a clear, then load bins, draw samples, with a little noise
    task automatic add_table_run(input bit fill_up);
        int n;
        int style;
        if (fill_up || $urandom_range(0, 3) != 0)
            add_item(FN_CLEAR, $urandom, 16'($urandom), 16'($urandom));
        if (fill_up) n = DEPTH + $urandom_range(2, 6);
        else if ($urandom_range(0, 9) == 0) n = $urandom_range(40, 200);
        else n = $urandom_range(1, 24);
        // the filling run uses only non-zero weights so that it really reaches full
        style = fill_up ? $urandom_range(0, 2) : $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
            add_item(FN_APPEND, $urandom, pick_weight(style), 16'($urandom));
            if ($urandom_range(0, 7) == 0)
                add_item(FN_SAMPLE, $urandom, 16'($urandom), pick_uniform());
        end
        for (int k = $urandom_range(1, 16); k > 0; k--)
            add_item(FN_SAMPLE, $urandom, 16'($urandom), pick_uniform());
        if ($urandom_range(0, 5) == 0)
            add_item(t_func'($urandom_range(0, 3)), $urandom, 16'($urandom), pick_uniform());
    endtask

    // Stimulus, then drain and verdict
    initial begin
        bit filled;
        filled = 1'b0;
        // directed: empty table, unused code, zero weight, value and weight extremes
        add_item(FN_SAMPLE, 32'h0, 16'h0, 16'h0000);
        add_item(FN_UNUSED, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
        add_item(FN_APPEND, 32'hFFFFFFFF, 16'h0000, 16'hFFFF);
        add_item(FN_SAMPLE, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
        add_item(FN_APPEND, 32'h7FFFFFFF, 16'hFFFF, 16'h0);
        add_item(FN_APPEND, 32'h80000000, 16'h0001, 16'h0);
        add_item(FN_APPEND, 32'h00000000, 16'hFFFF, 16'h0);
        add_item(FN_APPEND, 32'h5555AAAA, 16'h0000, 16'h0);
        add_item(FN_APPEND, 32'hFFFFFFFF, 16'h0001, 16'h0);
        add_item(FN_SAMPLE, 32'h0, 16'h0, 16'h0000);
        add_item(FN_SAMPLE, 32'h0, 16'h0, 16'hFFFF);
        add_item(FN_SAMPLE, 32'h0, 16'h0, 16'h7FFF);
        add_item(FN_SAMPLE, 32'h0, 16'h0, 16'h8000);
        add_item(FN_SAMPLE, 32'h0, 16'h0, 16'h0001);
        add_item(FN_UNUSED, 32'h0, 16'h0, 16'h0);
        add_item(FN_CLEAR, 32'hAAAA5555, 16'hFFFF, 16'hFFFF);
        add_item(FN_SAMPLE, 32'h0, 16'h0, 16'h1234);
        add_item(FN_APPEND, 32'h00010000, 16'h0001, 16'h0);
        add_item(FN_SAMPLE, 32'h0, 16'h0, 16'h0000);
        add_item(FN_SAMPLE, 32'h0, 16'h0, 16'hFFFF);

        // random table runs; one of them fills the table past full
        while (items_made < ITEM_GOAL) begin
            if (!filled && items_made >= ITEM_GOAL / 3) begin
                add_table_run(1'b1);
                filled = 1'b1;
            end else begin
                add_table_run(1'b0);
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (items_to_send.size() != 0 || i_in_valid) @(posedge i_clk);
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0 && pending_draws.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Driver: bursts of beats with random gaps, no gaps during the hold-off
    always @(negedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // stalled beat holds
        end else if (gap_left > 0 && hold_left == 0) begin
            i_in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (items_to_send.size() != 0) begin
            it = items_to_send.pop_front();
            i_func        <= it.func;
            i_point_value <= it.point_value;
            i_weight      <= it.weight;
            i_uniform     <= it.uniform;
            i_in_valid    <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 32);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver stall: shifting patterns, plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && beats_in >= HOLD_AT) begin
            i_out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(8, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 7) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // Monitor: check result beats, then predict for accepted input beats
    always @(posedge i_clk) begin
        t_draw want;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_draws.size() == 0) begin
                    report_mismatch("unexpected result, status", o_status, 0);
                end else begin
                    want = pending_draws.pop_front();
                    if (o_sample_value !== want.value)
                        report_mismatch("sample_value", o_sample_value, want.value);
                    if (o_sample_index !== want.index)
                        report_mismatch("sample_index", o_sample_index, want.index);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                end
                beats_out++;
            end
            if (i_in_valid && !o_in_stall) begin
                pending_draws.push_back(apply_to_table('{t_func'(i_func), i_point_value,
                                                         i_weight, i_uniform}));
                beats_in++;
            end
        end
    end

endmodule
